### rtl/slab_free_list_allocator_core_assert.svh
// Assertion macros used by the slab allocator checker.
// Plain text, no dependencies; pulled in by `include.
`ifndef SLAB_FREE_LIST_ALLOCATOR_CORE_ASSERT_SVH
`define SLAB_FREE_LIST_ALLOCATOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SFLA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("slab allocator check failed (same cycle)");

// Next-cycle implication, disabled during reset.
`define SFLA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("slab allocator check failed (next cycle)");

`endif

### rtl/sfla_pkg.sv
// Types and constants of the slab free-list allocator.
// No dependencies; imported by the allocator top level, its checker and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package sfla_pkg;

   localparam int SLOTS   = 1024;
   localparam int SLOT_W  = $clog2(SLOTS);
   localparam int CNT_W   = $clog2(SLOTS + 1);
   localparam int LIMIT_W = 12;
   // memory word: occupied mark on top, free-list link below
   localparam int MEM_W   = CNT_W + 1;

   localparam logic [LIMIT_W-1:0] RESET_THRESHOLD = LIMIT_W'(128);
   localparam logic [CNT_W-1:0]   SLOTS_CNT       = CNT_W'(SLOTS);

   typedef enum logic [1:0] {
      REQ_ALLOC   = 2'd0,
      REQ_FREE    = 2'd1,
      REQ_GC_DONE = 2'd2,
      REQ_QUERY   = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_GC_DUE   = 2'd1,
      ST_FULL     = 2'd2,
      ST_BAD_FREE = 2'd3
   } status_type;

   typedef struct packed {
      req_kind_type      req_type;
      logic [SLOT_W-1:0] slot;
   } sfla_req_type;

   typedef struct packed {
      logic [SLOT_W-1:0] slot_out;
      status_type        status;
      logic              is_occupied;
      logic [CNT_W-1:0]  occupied_total;
   } sfla_rsp_type;

endpackage

`default_nettype wire

### rtl/sfla_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module sfla_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // read data holds while re is low
   always_ff @(posedge clock) begin
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end

endmodule

`default_nettype wire

### rtl/slab_free_list_allocator_core.sv
// Top level of the slab free-list allocator: request decode, slot memory
// read-modify-write, allocator state and response register. Uses sfla_pkg, sfla_ram.
//
//   Channel   Ports                               Direction  Moves
//   --------  ----------------------------------  ---------  ------------------------
//   request   req_valid / req_ready / req_data    in         alloc, free, gc_done, query
//   response  rsp_valid / rsp_ready / rsp_data    out        one result per request
//   csr       csr_we / csr_wdata                  in         initial_gc_threshold
//
// On acceptance a request issues the slot memory read; in the execute stage it gets
// the read data, updates the state and writes the memory back. The registered read of
// the slot memory sets this; a new request is taken only once the previous one has
// retired. Reset is synchronous; it empties the allocator and loads the
// collection limit with 128. A stalled response holds the finished request in the
// execute stage (memory read data held) while the next request waits.
`timescale 1ns / 1ps
`default_nettype none

module slab_free_list_allocator_core (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire sfla_pkg::sfla_req_type req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output sfla_pkg::sfla_rsp_type      rsp_data,
   input  wire logic                   csr_we,
   input  wire logic [sfla_pkg::LIMIT_W-1:0] csr_wdata
);
   import sfla_pkg::*;

   // execute stage: request whose memory read is in flight or done
   logic         s1_valid_ff, s1_valid_in;
   sfla_req_type s1_req_ff,   s1_req_in;

   // allocator state
   logic [CNT_W-1:0]   free_head_ff,     free_head_in;
   logic [CNT_W-1:0]   bump_top_ff,      bump_top_in;
   logic [CNT_W-1:0]   used_count_ff,    used_count_in;
   logic [LIMIT_W-1:0] collect_limit_ff, collect_limit_in;

   // response register
   logic         rsp_valid_ff, rsp_valid_in;
   sfla_rsp_type rsp_data_ff,  rsp_data_in;

   // slot memory
   logic              mem_we;
   logic [SLOT_W-1:0] mem_waddr;
   logic [MEM_W-1:0]  mem_wdata;
   logic              mem_re;
   logic [SLOT_W-1:0] mem_raddr;
   logic [MEM_W-1:0]  mem_rdata;

   logic             req_accept;
   logic             s1_fire;
   logic             rd_used;
   logic [CNT_W-1:0] rd_link;
   logic             slot_in_range;

   sfla_ram #(
      .WIDTH (MEM_W),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   // one request in flight; the next is taken once it has retired
   assign req_ready  = !s1_valid_ff;
   assign req_accept = req_valid && req_ready;
   // retire when the response register is free or being emptied
   assign s1_fire    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);

   // alloc reads the link of the list head, free/query read the slot's mark.
   // An empty list points at bump_top; that read is then unused.
   assign mem_re    = req_accept;
   assign mem_raddr = (req_data.req_type == REQ_ALLOC) ? free_head_ff[SLOT_W-1:0]
                                                        : req_data.slot;

   assign rd_used = mem_rdata[CNT_W];
   assign rd_link = mem_rdata[CNT_W-1:0];

   // slot below bump_top: its entry has been written at least once
   assign slot_in_range = {1'b0, s1_req_ff.slot} < bump_top_ff;

   always_comb begin
      s1_valid_in      = s1_valid_ff;
      s1_req_in        = s1_req_ff;
      free_head_in     = free_head_ff;
      bump_top_in      = bump_top_ff;
      used_count_in    = used_count_ff;
      collect_limit_in = collect_limit_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_data_in      = rsp_data_ff;
      mem_we           = 1'b0;
      mem_waddr        = s1_req_ff.slot;
      mem_wdata        = '0;

      if (req_accept) begin
         s1_valid_in = 1'b1;
         s1_req_in   = req_data;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end

      if (s1_fire) begin
         rsp_data_in.slot_out    = s1_req_ff.slot;
         rsp_data_in.status      = ST_OK;
         rsp_data_in.is_occupied = 1'b0;

         unique case (s1_req_ff.req_type)
            REQ_ALLOC: begin
               priority if ({1'b0, used_count_ff} >= collect_limit_ff) begin
                  rsp_data_in.status = ST_GC_DUE;
               end else if (free_head_ff == bump_top_ff) begin
                  // free list empty: take the next untouched slot
                  if (bump_top_ff >= SLOTS_CNT) begin
                     rsp_data_in.status = ST_FULL;
                  end else begin
                     rsp_data_in.slot_out = bump_top_ff[SLOT_W-1:0];
                     mem_we        = 1'b1;
                     mem_waddr     = bump_top_ff[SLOT_W-1:0];
                     mem_wdata     = {1'b1, {CNT_W{1'b0}}};
                     bump_top_in   = bump_top_ff + CNT_W'(1);
                     free_head_in  = bump_top_ff + CNT_W'(1);
                     used_count_in = used_count_ff + CNT_W'(1);
                  end
               end else if (free_head_ff < SLOTS_CNT) begin
                  // pop the list head
                  rsp_data_in.slot_out = free_head_ff[SLOT_W-1:0];
                  mem_we        = 1'b1;
                  mem_waddr     = free_head_ff[SLOT_W-1:0];
                  mem_wdata     = {1'b1, rd_link};
                  free_head_in  = rd_link;
                  used_count_in = used_count_ff + CNT_W'(1);
               end else begin
                  rsp_data_in.status = ST_FULL;
               end
            end
            REQ_FREE: begin
               if (!slot_in_range || !rd_used) begin
                  rsp_data_in.status = ST_BAD_FREE;
               end else begin
                  // push onto the list, link stored in the slot
                  mem_we        = 1'b1;
                  mem_waddr     = s1_req_ff.slot;
                  mem_wdata     = {1'b0, free_head_ff};
                  free_head_in  = {1'b0, s1_req_ff.slot};
                  used_count_in = used_count_ff - CNT_W'(1);
               end
            end
            REQ_GC_DONE: begin
               // twice an 11-bit count fits 12 bits, never above the 4095 cap
               collect_limit_in = {used_count_ff, 1'b0};
            end
            REQ_QUERY: begin
               rsp_data_in.is_occupied = slot_in_range && rd_used;
            end
            default: begin
               rsp_data_in.status = ST_OK;
            end
         endcase

         rsp_data_in.occupied_total = used_count_in;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // threshold write loads the limit at once; the user must do it only while idle, the block does not enforce it
      if (csr_we) begin
         collect_limit_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         free_head_ff     <= '0;
         bump_top_ff      <= '0;
         used_count_ff    <= '0;
         collect_limit_ff <= RESET_THRESHOLD;
      end else begin
         s1_valid_ff      <= s1_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
         free_head_ff     <= free_head_in;
         bump_top_ff      <= bump_top_in;
         used_count_ff    <= used_count_in;
         collect_limit_ff <= collect_limit_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_req_ff   <= s1_req_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

### rtl/sfla_checker.sv
// Port-level checks of the slab allocator, bound to the top level.
// Uses sfla_pkg and slab_free_list_allocator_core_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "slab_free_list_allocator_core_assert.svh"

module sfla_checker (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_valid,
   input wire logic                   req_ready,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_ready,
   input wire sfla_pkg::sfla_rsp_type rsp_data
);
   import sfla_pkg::*;

   // stalled response stays put
   `SFLA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // only one request in flight
   `SFLA_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready)

   // occupied count never exceeds the store
   `SFLA_ASSERT_NOW(a_total_bound, clock, reset, rsp_valid, rsp_data.occupied_total <= SLOTS_CNT)

   // a failed request never reports an occupied slot
   `SFLA_ASSERT_NOW(a_err_not_occ, clock, reset, rsp_valid && rsp_data.status != ST_OK, !rsp_data.is_occupied)

endmodule

bind slab_free_list_allocator_core sfla_checker u_sfla_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

### dv/slab_free_list_allocator_core_tb.sv
// Self-checking testbench for slab_free_list_allocator_core: directed table, then random
// phases under several collection limits, scored against a built-in allocator predictor.
// Depends on sfla_pkg and the allocator RTL only.
`timescale 1ns / 1ps

module slab_free_list_allocator_core_tb;
   import sfla_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int MAX_REPORTS = 10;
   localparam int DIR_ROWS    = 25;
   localparam logic [LIMIT_W-1:0] LIMIT_MAX = '1;

   // one row of the directed table: either a limit write or a request
   typedef struct {
      bit                 cfg;
      logic [LIMIT_W-1:0] cfg_val;
      req_kind_type       kind;
      int                 slot;
      bit                 typed;
      sfla_rsp_type       rsp;
   } stim_row_type;

   // rides along with each request until it is accepted
   typedef struct {
      bit           typed;
      sfla_rsp_type rsp;
   } row_chk_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   sfla_req_type       req_data;
   logic               rsp_valid;
   logic               rsp_ready;
   sfla_rsp_type       rsp_data;
   logic               csr_we;
   logic [LIMIT_W-1:0] csr_wdata;

   slab_free_list_allocator_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // ---------------------------------------------------------------------------------------
   // Predictor state: its own copy of the allocator
   // ---------------------------------------------------------------------------------------
   bit               occ_mark [SLOTS];
   logic [CNT_W-1:0] link_mem [SLOTS];   // link is count-wide: it can hold SLOTS
   logic [CNT_W-1:0] head_ptr = '0;
   logic [CNT_W-1:0] bump_ptr = '0;
   logic [CNT_W-1:0] live_cnt = '0;
   logic [LIMIT_W-1:0] gc_limit = RESET_THRESHOLD;

   sfla_rsp_type owed_rsp_q [$];   // responses owed by the block, oldest first
   row_chk_type  row_chk_q [$];    // per-request typed expectation, in issue order
   stim_row_type dir_tab [DIR_ROWS];

   int  miss_cnt  = 0;
   int  rsp_count = 0;
   int  full_seen = 0;
   int  cyc       = 0;
   bit  calm      = 0;             // sender runs back to back while set

   // Works out the response to one request and advances the predictor state.
   function automatic sfla_rsp_type next_alloc_rsp(sfla_req_type r);
      sfla_rsp_type      o;
      logic [SLOT_W-1:0] got;
      logic [LIMIT_W:0]  dbl;
      o.slot_out    = r.slot;
      o.status      = ST_OK;
      o.is_occupied = 1'b0;
      case (r.req_type)
         REQ_ALLOC: begin
            if ({1'b0, live_cnt} >= gc_limit) begin
               o.status = ST_GC_DUE;
            end else if (head_ptr == bump_ptr) begin
               // free list empty: bump allocate or report full
               if (bump_ptr >= SLOTS_CNT) begin
                  o.status = ST_FULL;
               end else begin
                  o.slot_out = bump_ptr[SLOT_W-1:0];
                  occ_mark[bump_ptr[SLOT_W-1:0]] = 1'b1;
                  bump_ptr = bump_ptr + 1'b1;
                  head_ptr = bump_ptr;
                  live_cnt = live_cnt + 1'b1;
               end
            end else if (head_ptr < SLOTS_CNT) begin
               // pop the free list head (LIFO reuse)
               got = head_ptr[SLOT_W-1:0];
               head_ptr = link_mem[got];
               occ_mark[got] = 1'b1;
               live_cnt = live_cnt + 1'b1;
               o.slot_out = got;
            end else begin
               o.status = ST_FULL;
            end
         end
         REQ_FREE: begin
            // out-of-range is tested first so an unwritten mark is never read
            if ({1'b0, r.slot} >= bump_ptr) begin
               o.status = ST_BAD_FREE;
            end else if (!occ_mark[r.slot]) begin
               o.status = ST_BAD_FREE;
            end else begin
               occ_mark[r.slot] = 1'b0;
               link_mem[r.slot] = head_ptr;
               head_ptr = {1'b0, r.slot};
               live_cnt = live_cnt - 1'b1;
            end
         end
         REQ_GC_DONE: begin
            dbl = {live_cnt, 1'b0};
            gc_limit = (dbl > LIMIT_MAX) ? LIMIT_MAX : dbl[LIMIT_W-1:0];
         end
         default: begin
            if ({1'b0, r.slot} < bump_ptr)
               o.is_occupied = occ_mark[r.slot];
         end
      endcase
      o.occupied_total = live_cnt;
      return o;
   endfunction

   function automatic stim_row_type rq(req_kind_type k, int s, bit t, int so, status_type st,
                                       bit oc, int tot);
      stim_row_type r;
      r.cfg                = 1'b0;
      r.cfg_val            = '0;
      r.kind               = k;
      r.slot               = s;
      r.typed              = t;
      r.rsp.slot_out       = so[SLOT_W-1:0];
      r.rsp.status         = st;
      r.rsp.is_occupied    = oc;
      r.rsp.occupied_total = tot[CNT_W-1:0];
      return r;
   endfunction

   function automatic stim_row_type cf(int v);
      stim_row_type r;
      r         = rq(REQ_QUERY, 0, 1'b0, 0, ST_OK, 1'b0, 0);
      r.cfg     = 1'b1;
      r.cfg_val = v[LIMIT_W-1:0];
      return r;
   endfunction

   // mostly back to back, some short gaps, a few long ones
   function automatic int idle_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 85) return $urandom_range(1, 3);
      if (p < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // bias toward slots that have been handed out, so frees and queries hit
   function automatic int pick_slot();
      if (bump_ptr != 0 && $urandom_range(0, 99) < 75)
         return $urandom_range(0, int'(bump_ptr) - 1);
      return $urandom_range(0, SLOTS - 1);
   endfunction

   function automatic req_kind_type pick_kind(int pa, int pf, int pg);
      int p;
      p = $urandom_range(0, 99);
      if (p < pa) return REQ_ALLOC;
      if (p < pa + pf) return REQ_FREE;
      if (p < pa + pf + pg) return REQ_GC_DONE;
      return REQ_QUERY;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Clock, timeout
   // ---------------------------------------------------------------------------------------
   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cyc <= cyc + 1;
      if (cyc > CYCLE_LIMIT) begin
         $display("slab_free_list_allocator_core_tb: errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Monitor: score responses, predict accepted requests, track limit writes.
   // Responses are scored before the same-edge request is predicted.
   // ---------------------------------------------------------------------------------------
   task automatic note_miss(string what, sfla_rsp_type want, sfla_rsp_type got);
      miss_cnt++;
      if (miss_cnt <= MAX_REPORTS)
         $display("MISMATCH %s at cycle %0d: exp slot=%0d st=%0d occ=%0d tot=%0d, got slot=%0d st=%0d occ=%0d tot=%0d",
                  what, cyc, want.slot_out, want.status, want.is_occupied,
                  want.occupied_total, got.slot_out, got.status, got.is_occupied,
                  got.occupied_total);
   endtask

   always @(posedge clock) begin : scoreboard
      sfla_rsp_type want;
      sfla_rsp_type pred;
      row_chk_type  chk;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            rsp_count++;
            if (owed_rsp_q.size() == 0) begin
               note_miss("unexpected response", '0, rsp_data);
            end else begin
               want = owed_rsp_q.pop_front();
               if (rsp_data.slot_out !== want.slot_out || rsp_data.status !== want.status ||
                   rsp_data.is_occupied !== want.is_occupied ||
                   rsp_data.occupied_total !== want.occupied_total)
                  note_miss("field", want, rsp_data);
            end
         end
         if (req_valid && req_ready) begin
            chk  = row_chk_q.pop_front();
            pred = next_alloc_rsp(req_data);
            if (pred.status == ST_FULL)
               full_seen++;
            owed_rsp_q.push_back(chk.typed ? chk.rsp : pred);
         end
         if (csr_we)
            gc_limit = csr_wdata;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Response side: random ready, with one long hold-off after the 50th response so the
   // pipeline fills and req_ready drops while requests keep coming.
   // ---------------------------------------------------------------------------------------
   initial begin : rsp_side
      bit held;
      held      = 1'b0;
      rsp_ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!held && rsp_count >= 50) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (300) @(posedge clock);
         end else if ($urandom_range(0, 99) < 70) begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b0;
            repeat (1 + idle_len()) @(posedge clock);
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Request side. Every task below is entered right after a rising edge.
   // ---------------------------------------------------------------------------------------
   task automatic issue(req_kind_type k, int s, bit has, sfla_rsp_type want);
      sfla_req_type r;
      row_chk_type  c;
      int           g;
      r.req_type = k;
      r.slot     = s[SLOT_W-1:0];
      c.typed    = has;
      c.rsp      = want;
      row_chk_q.push_back(c);
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      g = calm ? 0 : idle_len();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   // stop offering and wait for every owed response, plus pipeline slack.
   // It first waits for the next edge, so a request accepted at the entry edge is already owed.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (owed_rsp_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_limit(logic [LIMIT_W-1:0] v);
      settle();
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_mix(int n, int pa, int pf, int pg);
      for (int i = 0; i < n; i++) begin
         if (i % 50 == 0)
            calm = ($urandom_range(0, 99) < 25);
         issue(pick_kind(pa, pf, pg), pick_slot(), 1'b0, '0);
      end
   endtask

   initial begin : stimulus
      int n;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_wdata = '0;

      // Directed: empty store at the reset limit, zero limit, a limit of two, LIFO reuse.
      dir_tab[0]  = rq(REQ_QUERY,   0,    1, 0,    ST_OK,       0, 0);
      dir_tab[1]  = rq(REQ_FREE,    0,    1, 0,    ST_BAD_FREE, 0, 0);
      dir_tab[2]  = rq(REQ_FREE,    1023, 1, 1023, ST_BAD_FREE, 0, 0);
      dir_tab[3]  = rq(REQ_QUERY,   1023, 1, 1023, ST_OK,       0, 0);
      dir_tab[4]  = rq(REQ_GC_DONE, 1023, 1, 1023, ST_OK,       0, 0);  // limit -> 0
      dir_tab[5]  = rq(REQ_ALLOC,   1023, 1, 1023, ST_GC_DUE,   0, 0);  // zero limit
      dir_tab[6]  = cf(2);
      dir_tab[7]  = rq(REQ_ALLOC,   1023, 1, 0,    ST_OK,       0, 1);
      dir_tab[8]  = rq(REQ_ALLOC,   0,    1, 1,    ST_OK,       0, 2);
      dir_tab[9]  = rq(REQ_ALLOC,   7,    1, 7,    ST_GC_DUE,   0, 2);
      dir_tab[10] = rq(REQ_QUERY,   1,    1, 1,    ST_OK,       1, 2);
      dir_tab[11] = rq(REQ_QUERY,   2,    1, 2,    ST_OK,       0, 2);  // above bump ptr
      dir_tab[12] = rq(REQ_FREE,    0,    1, 0,    ST_OK,       0, 1);
      dir_tab[13] = rq(REQ_FREE,    0,    1, 0,    ST_BAD_FREE, 0, 1);  // already vacant
      dir_tab[14] = rq(REQ_QUERY,   0,    1, 0,    ST_OK,       0, 1);
      dir_tab[15] = rq(REQ_ALLOC,   512,  1, 0,    ST_OK,       0, 2);  // reuse freed slot
      dir_tab[16] = rq(REQ_GC_DONE, 0,    1, 0,    ST_OK,       0, 2);  // limit -> 4
      dir_tab[17] = rq(REQ_FREE,    1,    0, 0,    ST_OK,       0, 0);
      dir_tab[18] = rq(REQ_FREE,    0,    0, 0,    ST_OK,       0, 0);
      dir_tab[19] = rq(REQ_ALLOC,   341,  0, 0,    ST_OK,       0, 0);
      dir_tab[20] = rq(REQ_ALLOC,   682,  0, 0,    ST_OK,       0, 0);
      dir_tab[21] = rq(REQ_ALLOC,   1,    0, 0,    ST_OK,       0, 0);
      dir_tab[22] = rq(REQ_ALLOC,   2,    0, 0,    ST_OK,       0, 0);
      dir_tab[23] = rq(REQ_ALLOC,   1023, 1, 1023, ST_GC_DUE,   0, 4);
      dir_tab[24] = rq(REQ_FREE,    1023, 1, 1023, ST_BAD_FREE, 0, 4);

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_tab[i]) begin
         if (dir_tab[i].cfg)
            write_limit(dir_tab[i].cfg_val);
         else
            issue(dir_tab[i].kind, dir_tab[i].slot, dir_tab[i].typed, dir_tab[i].rsp);
      end

      // Small limit, churn; the long response hold-off lands here. Mid-phase full drain.
      write_limit(16);
      run_mix(45, 40, 35, 10);
      settle();
      run_mix(25, 40, 35, 10);

      // Zero limit: allocs refused until a gc_done with live slots raises it.
      write_limit(0);
      run_mix(30, 50, 20, 15);

      // Top limit: allocate hard until the store has reported full several times,
      // then free and reuse from a full store.
      write_limit(LIMIT_MAX);
      n = 0;
      while (full_seen < 6 && n < 1500) begin
         if (n % 50 == 0)
            calm = ($urandom_range(0, 99) < 25);
         issue(pick_kind(96, 2, 1), pick_slot(), 1'b0, '0);
         n++;
      end
      run_mix(50, 30, 55, 5);

      write_limit(12'd2048);
      run_mix(40, 30, 50, 10);

      write_limit(12'd1);
      run_mix(30, 45, 35, 10);

      write_limit(LIMIT_W'($urandom_range(1, 2047)));
      run_mix(60, 45, 35, 5);

      settle();
      repeat (10) @(posedge clock);
      if (miss_cnt == 0 && owed_rsp_q.size() == 0)
         $display("slab_free_list_allocator_core_tb: clean");
      else
         $display("slab_free_list_allocator_core_tb: errors");
      $finish;
   end

endmodule
